[rtl/fcgi_pkg.sv]
// Shared types and constants for the FIFO cache with generation invalidate.
// No dependencies; imported by every module of the block.
package fcgi_pkg;

  localparam int SLOTS    = 64;
  localparam int SLOT_W   = 6;
  localparam int CNT_W    = 7;
  localparam int IDENTS   = 256;
  localparam int ID_W     = 8;
  localparam int GEN_BITS = 32;
  localparam int TAG_W    = 32;
  localparam int HND_W    = 32;
  localparam int STAT_W   = 32;

  localparam logic [1:0] REQ_GET       = 2'd0;
  localparam logic [1:0] REQ_PUT       = 2'd1;
  localparam logic [1:0] REQ_FLUSH_ALL = 2'd2;
  localparam logic [1:0] REQ_FLUSH_ID  = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [HND_W-1:0]    handle;
    logic [GEN_BITS-1:0] gstamp;
    logic [GEN_BITS-1:0] istamp;
    logic [CNT_W-1:0]    age;
  } slot_word_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_word_t        wdata;
    logic [SLOT_W-1:0] raddr;
  } slot_req_t;

endpackage

[rtl/fcgi_slot_ram.sv]
// Slot store: tag, handle, stamps and FIFO rank per slot.
// One write and one registered read per cycle. Depends on fcgi_pkg.
module fcgi_slot_ram import fcgi_pkg::*; (
  input  logic       clk,
  input  slot_req_t  req,
  output slot_word_t rdata_r
);

  slot_word_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

endmodule

[rtl/fcgi_gen_ram.sv]
// Identity generation store with per-entry valid bits; unwritten reads as zero.
// Registered read. Depends on fcgi_pkg.
module fcgi_gen_ram import fcgi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [ID_W-1:0]     raddr,
  input  logic                we,
  input  logic [ID_W-1:0]     waddr,
  input  logic [GEN_BITS-1:0] wdata,
  output logic [GEN_BITS-1:0] rdata
);

  logic [GEN_BITS-1:0] mem [IDENTS];
  logic [IDENTS-1:0]   vld_r;
  logic [GEN_BITS-1:0] rdata_r;
  logic                rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

[rtl/fifo_cache_generation_invalidate.sv]
// Top level: FIFO cache with lazy generation invalidation, control FSM, APB regs.
// Depends on fcgi_pkg, fcgi_slot_ram, fcgi_gen_ram.
//
//  channel  | handshake              | beat
//  in_      | start & !busy          | req_type, key_tag, identity_id, policy_handle
//  out_     | out_valid (1 cycle)    | hit, handle, versions, count, statistics
//  config   | psel & penable & pwrite| entry_limit at any paddr with paddr[2] clear
//
// Flushes pass through accept, a generation step and the result. A get or a put of a
// present key adds one pass over the slot RAM between generation read and result.
// A put of a new key adds an insert step. A stale drop adds a rank renumbering
// sweep; each FIFO eviction adds a search for the oldest, a sweep, and a recheck
// of the limit.
// Synchronous reset clears valid bits, generations and counters at once.
// Results cannot be stalled; busy stays high through the result beat.
module fifo_cache_generation_invalidate import fcgi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [TAG_W-1:0]  in_key_tag,
  input  logic [ID_W-1:0]   in_identity_id,
  input  logic [HND_W-1:0]  in_policy_handle,
  output logic              out_valid,
  output logic              out_hit,
  output logic [HND_W-1:0]  out_hit_handle,
  output logic [31:0]       out_global_version,
  output logic [31:0]       out_identity_version,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic [STAT_W-1:0] out_hit_count,
  output logic [STAT_W-1:0] out_miss_count,
  output logic [STAT_W-1:0] out_eviction_count,
  output logic [STAT_W-1:0] out_flush_all_count,
  output logic [STAT_W-1:0] out_flush_identity_count,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_GEN, S_SCAN, S_SWEEP, S_INSERT, S_RESP
  } state_t;

  state_t              state_r;
  logic [1:0]          req_r;
  logic [TAG_W-1:0]    key_r;
  logic [ID_W-1:0]     ident_r;
  logic [HND_W-1:0]    handle_r;
  logic [GEN_BITS-1:0] idv_r;
  logic [GEN_BITS-1:0] gg_r;
  logic [CNT_W-1:0]    limit_r;
  logic [CNT_W-1:0]    held_r;
  logic [SLOTS-1:0]    slot_vld_r;
  logic [CNT_W-1:0]    scan_r;
  logic                pend_r;
  logic [SLOT_W-1:0]   addr_d_r;
  logic                mode_old_r;
  logic [SLOT_W-1:0]   free_r;
  logic [CNT_W-1:0]    rank_r;
  logic                after_ins_r;
  logic                hit_r;
  logic [HND_W-1:0]    hit_handle_r;
  logic [STAT_W-1:0]   hit_cnt_r;
  logic [STAT_W-1:0]   miss_cnt_r;
  logic [STAT_W-1:0]   ev_cnt_r;
  logic [STAT_W-1:0]   fa_cnt_r;
  logic [STAT_W-1:0]   fi_cnt_r;

  slot_req_t           slot_req;
  slot_word_t          rd_word;
  logic [ID_W-1:0]     gen_raddr;
  logic                gen_we;
  logic [GEN_BITS-1:0] gen_rd;
  logic [GEN_BITS-1:0] gen_inc;

  logic                issue;
  logic                cur_vld;
  logic                match;
  logic                stale;
  logic                restart;
  logic [CNT_W-1:0]    lim_eff;
  logic                full;
  logic                cfg_we;

  fcgi_slot_ram u_slot_ram (
    .clk     (clk),
    .req     (slot_req),
    .rdata_r (rd_word)
  );

  fcgi_gen_ram u_gen_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (gen_raddr),
    .we    (gen_we),
    .waddr (ident_r),
    .wdata (gen_inc),
    .rdata (gen_rd)
  );

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32-CNT_W){1'b0}}, limit_r};

  assign issue   = !scan_r[CNT_W-1];
  assign cur_vld = slot_vld_r[addr_d_r];
  assign stale   = (rd_word.gstamp != gg_r) || (rd_word.istamp != idv_r);
  assign match   = pend_r && cur_vld &&
                   (mode_old_r ? (rd_word.age == '0) : (rd_word.tag == key_r));
  assign restart = match && (mode_old_r || (req_r == REQ_GET && stale));

  always_comb begin
    if (limit_r == '0) begin
      lim_eff = CNT_W'(1);
    end else if (limit_r > CNT_W'(SLOTS)) begin
      lim_eff = CNT_W'(SLOTS);
    end else begin
      lim_eff = limit_r;
    end
  end
  assign full = held_r >= lim_eff;

  assign gen_raddr = (state_r == S_IDLE) ? in_identity_id : ident_r;
  assign gen_we    = (state_r == S_GEN) && (req_r == REQ_FLUSH_ID);
  assign gen_inc   = gen_rd + GEN_BITS'(1);

  always_comb begin
    slot_req.we    = 1'b0;
    slot_req.waddr = addr_d_r;
    slot_req.wdata = rd_word;
    slot_req.raddr = scan_r[SLOT_W-1:0];
    unique case (state_r)
      S_SCAN: begin
        if (match && !mode_old_r && req_r == REQ_PUT) begin
          slot_req.we    = 1'b1;
          slot_req.wdata = '{tag: key_r, handle: handle_r, gstamp: gg_r,
                             istamp: idv_r, age: rd_word.age};
        end
      end
      S_SWEEP: begin
        if (pend_r && cur_vld && rd_word.age > rank_r) begin
          slot_req.we        = 1'b1;
          slot_req.wdata.age = rd_word.age - CNT_W'(1);
        end
      end
      S_INSERT: begin
        if (!full) begin
          slot_req.we    = 1'b1;
          slot_req.waddr = free_r;
          slot_req.wdata = '{tag: key_r, handle: handle_r, gstamp: gg_r,
                             istamp: idv_r, age: held_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gg_r        <= '0;
      limit_r     <= CNT_W'(SLOTS);
      held_r      <= '0;
      slot_vld_r  <= '0;
      hit_r       <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      ev_cnt_r    <= '0;
      fa_cnt_r    <= '0;
      fi_cnt_r    <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      mode_old_r  <= 1'b0;
      after_ins_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= pwdata[CNT_W-1:0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r        <= in_req_type;
            key_r        <= in_key_tag;
            ident_r      <= in_identity_id;
            handle_r     <= in_policy_handle;
            hit_r        <= 1'b0;
            hit_handle_r <= '0;
            state_r      <= S_GEN;
          end
        end
        S_GEN: begin
          unique case (req_r)
            REQ_FLUSH_ALL: begin
              idv_r    <= gen_rd;
              gg_r     <= gg_r + GEN_BITS'(1);
              fa_cnt_r <= fa_cnt_r + STAT_W'(1);
              state_r  <= S_RESP;
            end
            REQ_FLUSH_ID: begin
              idv_r    <= gen_inc;
              fi_cnt_r <= fi_cnt_r + STAT_W'(1);
              state_r  <= S_RESP;
            end
            default: begin
              idv_r      <= gen_rd;
              scan_r     <= '0;
              pend_r     <= 1'b0;
              mode_old_r <= 1'b0;
              state_r    <= S_SCAN;
            end
          endcase
        end
        S_SCAN: begin
          addr_d_r <= scan_r[SLOT_W-1:0];
          if (restart) begin
            scan_r <= '0;
            pend_r <= 1'b0;
          end else begin
            scan_r <= scan_r + CNT_W'(issue);
            pend_r <= issue;
          end
          if (match) begin
            if (mode_old_r) begin
              slot_vld_r[addr_d_r] <= 1'b0;
              held_r      <= held_r - CNT_W'(1);
              ev_cnt_r    <= ev_cnt_r + STAT_W'(1);
              free_r      <= addr_d_r;
              rank_r      <= rd_word.age;
              after_ins_r <= 1'b1;
              state_r     <= S_SWEEP;
            end else if (req_r == REQ_GET) begin
              if (stale) begin
                slot_vld_r[addr_d_r] <= 1'b0;
                held_r      <= held_r - CNT_W'(1);
                miss_cnt_r  <= miss_cnt_r + STAT_W'(1);
                rank_r      <= rd_word.age;
                after_ins_r <= 1'b0;
                state_r     <= S_SWEEP;
              end else begin
                hit_r        <= 1'b1;
                hit_handle_r <= rd_word.handle;
                hit_cnt_r    <= hit_cnt_r + STAT_W'(1);
                state_r      <= S_RESP;
              end
            end else begin
              state_r <= S_RESP;
            end
          end else begin
            if (pend_r && !cur_vld && !mode_old_r) begin
              free_r <= addr_d_r;
            end
            if (!issue) begin
              if (!mode_old_r && req_r == REQ_GET) begin
                miss_cnt_r <= miss_cnt_r + STAT_W'(1);
                state_r    <= S_RESP;
              end else begin
                state_r <= S_INSERT;
              end
            end
          end
        end
        S_SWEEP: begin
          scan_r   <= scan_r + CNT_W'(issue);
          pend_r   <= issue;
          addr_d_r <= scan_r[SLOT_W-1:0];
          if (!issue) begin
            state_r <= after_ins_r ? S_INSERT : S_RESP;
          end
        end
        S_INSERT: begin
          if (full) begin
            mode_old_r <= 1'b1;
            scan_r     <= '0;
            pend_r     <= 1'b0;
            state_r    <= S_SCAN;
          end else begin
            slot_vld_r[free_r] <= 1'b1;
            held_r  <= held_r + CNT_W'(1);
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                     = (state_r != S_IDLE);
  assign out_valid                = (state_r == S_RESP);
  assign out_hit                  = hit_r;
  assign out_hit_handle           = hit_handle_r;
  assign out_global_version       = gg_r[31:0];
  assign out_identity_version     = idv_r[31:0];
  assign out_entry_count          = held_r;
  assign out_hit_count            = hit_cnt_r;
  assign out_miss_count           = miss_cnt_r;
  assign out_eviction_count       = ev_cnt_r;
  assign out_flush_all_count      = fa_cnt_r;
  assign out_flush_identity_count = fi_cnt_r;

  a_held_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    held_r == CNT_W'($countones(slot_vld_r)))
    else $error("entry count differs from valid slots");

  a_resp_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result beat longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted beat did not raise busy");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !slot_req.we && !gen_we)
    else $error("memory write while idle");

endmodule
